>>> design/pfrgb_pkg.sv
// ----------------------------------------------------------------------------
// pfrgb_pkg
// Shared widths, register indexes and divider geometry for the true-color
// pixel to RGB888 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfrgb_pkg;

  // Raw pixel and configuration widths.
  localparam int PIX_W     = 32;
  localparam int BPP_W     = 3;
  localparam int SHIFT_W   = 5;
  localparam int FIELD_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Scaling: numerator is field * 255, quotient is one 8-bit intensity.
  localparam int QUOT_W    = 8;
  localparam int NUM_W     = FIELD_W + QUOT_W;

  // The divider resolves two quotient bits in each of its stages.
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUOT_W / BITS_PER_STAGE;

  // Front stages: byte keep, field extract, multiply by 255.
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BPP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX    = 3'd6;

  // Per-channel format description.
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [FIELD_W-1:0] max;
  } chan_cfg_t;

endpackage

`default_nettype wire

>>> design/pfrgb_div.sv
// ----------------------------------------------------------------------------
// pfrgb_div
// Pipelined restoring divider that turns field * 255 into an 8-bit intensity.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrgb_div (
  input  wire logic                          clk,
  input  wire logic [pfrgb_pkg::NUM_W-1:0]   num,
  input  wire logic [pfrgb_pkg::FIELD_W-1:0] den,
  input  wire logic                          zero,
  output logic      [pfrgb_pkg::QUOT_W-1:0]  quot
);
  import pfrgb_pkg::*;

  // The numerator never reaches 256 times the divisor, so eight quotient bits
  // always suffice.
  logic [NUM_W-1:0]   rem_q  [DIV_STAGES];
  logic [FIELD_W-1:0] den_q  [DIV_STAGES];
  logic [QUOT_W-1:0]  quot_q [DIV_STAGES];
  logic               zero_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W-1:0]   rem_in;
    logic [FIELD_W-1:0] den_in;
    logic [QUOT_W-1:0]  quot_in;
    logic               zero_in;
    logic [NUM_W-1:0]   rem_next;
    logic [QUOT_W-1:0]  quot_next;

    if (s == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign quot_in = '0;
      assign zero_in = zero;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quot_in = quot_q[s-1];
      assign zero_in = zero_q[s-1];
    end

    always_comb begin
      logic [NUM_W-1:0] trial;
      int               bit_idx;
      rem_next  = rem_in;
      quot_next = quot_in;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        bit_idx = QUOT_W - 1 - s * BITS_PER_STAGE - j;
        trial   = NUM_W'(den_in) << bit_idx;
        if (rem_next >= trial) begin
          rem_next           = rem_next - trial;
          quot_next[bit_idx] = 1'b1;
        end
      end
      // A zero maximum scales to zero.
      if (zero_in) begin
        quot_next = '0;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s]  <= rem_next;
      den_q[s]  <= den_in;
      quot_q[s] <= quot_next;
      zero_q[s] <= zero_in;
    end
  end

  assign quot = quot_q[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> design/pixel_format_to_rgb888_core.sv
// ----------------------------------------------------------------------------
// pixel_format_to_rgb888_core
// Converts one true-color framebuffer pixel per clock into RGB888.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel beat is taken on raw_pixel at a rising edge where start is high
//   and busy is low. The first framebuffer byte sits in bits 7 to 0; bytes
//   beyond bytes_per_pixel are treated as zero.
//   Each channel is shifted down by its shift, masked by its maximum and
//   scaled as field * 255 / max with truncation; a zero maximum gives zero.
//   Results leave on red_out, green_out and blue_out for exactly one cycle,
//   marked by done.
//   The pipeline is seven registers deep (byte keep, field extract, times
//   255, then four divider stages of two quotient bits each) and takes a new
//   beat every cycle, so the sustained rate is one pixel per clock.
//   The receiver cannot stall, so nothing ever holds the pipeline.
//   Reset clears the valid chain and loads the default 32-bit xRGB format;
//   busy is high only while reset is asserted.
//   Configuration writes through cfg_write, cfg_index and cfg_data take
//   effect at once and must only be made while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_to_rgb888_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [pfrgb_pkg::PIX_W-1:0]     raw_pixel,
  input  wire logic                            cfg_write,
  input  wire logic [pfrgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pfrgb_pkg::CFG_W-1:0]     cfg_data,
  output logic                                 done,
  output logic      [pfrgb_pkg::QUOT_W-1:0]    red_out,
  output logic      [pfrgb_pkg::QUOT_W-1:0]    green_out,
  output logic      [pfrgb_pkg::QUOT_W-1:0]    blue_out
);
  import pfrgb_pkg::*;

  // Configuration registers.
  logic [BPP_W-1:0] bytes_per_pixel;
  chan_cfg_t        red_cfg;
  chan_cfg_t        green_cfg;
  chan_cfg_t        blue_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(4);
      red_cfg         <= '{shift: SHIFT_W'(16), max: FIELD_W'(255)};
      green_cfg       <= '{shift: SHIFT_W'(8),  max: FIELD_W'(255)};
      blue_cfg        <= '{shift: SHIFT_W'(0),  max: FIELD_W'(255)};
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BPP:         bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_RED_SHIFT:   red_cfg.shift   <= cfg_data[SHIFT_W-1:0];
        REG_GREEN_SHIFT: green_cfg.shift <= cfg_data[SHIFT_W-1:0];
        REG_BLUE_SHIFT:  blue_cfg.shift  <= cfg_data[SHIFT_W-1:0];
        REG_RED_MAX:     red_cfg.max     <= cfg_data[FIELD_W-1:0];
        REG_GREEN_MAX:   green_cfg.max   <= cfg_data[FIELD_W-1:0];
        REG_BLUE_MAX:    blue_cfg.max    <= cfg_data[FIELD_W-1:0];
        default: ;  // Unknown indexes are ignored.
      endcase
    end
  end

  // The pipeline never stalls, so it is ready whenever it is out of reset.
  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // Valid bits march alongside the data; the last one is the result strobe.
  logic [PIPE_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // Stage 1: keep only the low bytes that belong to the pixel. A size of
  // zero keeps nothing, and sizes above four keep the whole word.
  logic [PIX_W-1:0] keep_mask;
  logic [PIX_W-1:0] pix_q;

  always_comb begin
    unique case (bytes_per_pixel)
      3'd0:    keep_mask = 32'h0000_0000;
      3'd1:    keep_mask = 32'h0000_00FF;
      3'd2:    keep_mask = 32'h0000_FFFF;
      3'd3:    keep_mask = 32'h00FF_FFFF;
      default: keep_mask = 32'hFFFF_FFFF;
    endcase
  end

  always_ff @(posedge clk) begin
    pix_q <= raw_pixel & keep_mask;
  end

  // Stage 2: bring each field down to bit zero and mask it with its maximum.
  // The mask keeps higher channels from leaking into the field.
  logic [FIELD_W-1:0] red_field_q;
  logic [FIELD_W-1:0] green_field_q;
  logic [FIELD_W-1:0] blue_field_q;

  always_ff @(posedge clk) begin
    red_field_q   <= FIELD_W'(pix_q >> red_cfg.shift)   & red_cfg.max;
    green_field_q <= FIELD_W'(pix_q >> green_cfg.shift) & green_cfg.max;
    blue_field_q  <= FIELD_W'(pix_q >> blue_cfg.shift)  & blue_cfg.max;
  end

  // Stage 3: multiply by 255 as a shift and a subtract, and flag a zero
  // maximum so the divider can force that channel to zero.
  logic [NUM_W-1:0] red_num_q;
  logic [NUM_W-1:0] green_num_q;
  logic [NUM_W-1:0] blue_num_q;
  logic             red_zero_q;
  logic             green_zero_q;
  logic             blue_zero_q;

  always_ff @(posedge clk) begin
    red_num_q    <= (NUM_W'(red_field_q)   << QUOT_W) - NUM_W'(red_field_q);
    green_num_q  <= (NUM_W'(green_field_q) << QUOT_W) - NUM_W'(green_field_q);
    blue_num_q   <= (NUM_W'(blue_field_q)  << QUOT_W) - NUM_W'(blue_field_q);
    red_zero_q   <= (red_cfg.max == '0);
    green_zero_q <= (green_cfg.max == '0);
    blue_zero_q  <= (blue_cfg.max == '0);
  end

  // Stages 4 to 7: one pipelined divider per channel. The maximum is read
  // live; the user changes it only while no pixel is in flight, unchecked.
  pfrgb_div u_red_div (
    .clk  (clk),
    .num  (red_num_q),
    .den  (red_cfg.max),
    .zero (red_zero_q),
    .quot (red_out)
  );

  pfrgb_div u_green_div (
    .clk  (clk),
    .num  (green_num_q),
    .den  (green_cfg.max),
    .zero (green_zero_q),
    .quot (green_out)
  );

  pfrgb_div u_blue_div (
    .clk  (clk),
    .num  (blue_num_q),
    .den  (blue_cfg.max),
    .zero (blue_zero_q),
    .quot (blue_out)
  );

endmodule

`default_nettype wire
